FILE: rtl/core/kmsd_pkg.sv
// Shared constants and controller/datapath handshake types for the key matrix
// scan debouncer. No dependencies.
package kmsd_pkg;

    localparam int COL_W          = 4;
    localparam int ROW_W          = 5;
    localparam int TIME_W         = 32;
    localparam int QUIET_W        = 20;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 3;
    localparam int MAX_REPORT     = 16;
    localparam int NUM_COLUMNS_DEF = 16;
    localparam int NUM_ROWS_DEF    = 5;

    localparam logic [QUIET_W-1:0] QUIET_RESET = QUIET_W'(4 * 1000);

    // Register index, taken from the word address bit of paddr
    localparam logic REG_QUIET_TIME = 1'b0;

    typedef struct packed {
        logic accept;   // input transaction taken this cycle
        logic eval;     // end-of-scan timing decision
        logic load;     // load next column into the output register
    } t_ctl_cmd;

    typedef struct packed {
        logic in_valid;
        logic eos;        // end_of_scan of the offered input
        logic out_free;   // output register empty or being taken
        logic last_col;   // column counter at the last reported column
    } t_ctl_sts;

endpackage

FILE: rtl/core/kmsd_in_if.sv
// Column sample channel: valid/ready plus sample payload.
// Depends on kmsd_pkg.
interface kmsd_in_if;
    import kmsd_pkg::*;

    logic              valid;
    logic              ready;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row_bits;
    logic [TIME_W-1:0] now_us;
    logic              end_of_scan;

    modport source (output valid, column, row_bits, now_us, end_of_scan, input ready);
    modport sink   (input valid, column, row_bits, now_us, end_of_scan, output ready);
endinterface

FILE: rtl/core/kmsd_out_if.sv
// Debounced column result channel: valid/ready plus result payload.
// Depends on kmsd_pkg.
interface kmsd_out_if;
    import kmsd_pkg::*;

    logic             valid;
    logic             ready;
    logic [COL_W-1:0] out_column;
    logic [ROW_W-1:0] keys_down;
    logic             latched;
    logic             scan_changed;
    logic             last_of_run;

    modport source (output valid, out_column, keys_down, latched, scan_changed, last_of_run,
                    input ready);
    modport sink   (input valid, out_column, keys_down, latched, scan_changed, last_of_run,
                    output ready);
endinterface

FILE: rtl/core/kmsd_ctl.sv
// Sequencing FSM: takes samples, runs the end-of-scan decision, then walks
// the column report. Depends on kmsd_pkg.
module kmsd_ctl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kmsd_pkg::t_ctl_sts i_sts,
    output kmsd_pkg::t_ctl_cmd o_cmd,
    output logic               o_in_ready
);
    import kmsd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_sts.in_valid;
                if (i_sts.in_valid && i_sts.eos) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.load = i_sts.out_free;
                if (i_sts.out_free && i_sts.last_col) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/core/kmsd_dp.sv
// Datapath: previous-scan and debounced stores, quiet timer, config register,
// column counter and output register. Depends on kmsd_pkg and the channel interfaces.
module kmsd_dp #(
    parameter int NUM_COLUMNS = kmsd_pkg::NUM_COLUMNS_DEF,
    parameter int NUM_ROWS    = kmsd_pkg::NUM_ROWS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    kmsd_in_if.sink                             i_in,
    kmsd_out_if.source                          o_out,
    input  kmsd_pkg::t_ctl_cmd                  i_cmd,
    output kmsd_pkg::t_ctl_sts                  o_sts,
    input  logic                                i_cfg_we,
    input  logic [kmsd_pkg::QUIET_W-1:0]        i_cfg_wdata,
    output logic [kmsd_pkg::QUIET_W-1:0]        o_quiet
);
    import kmsd_pkg::*;

    localparam int REP = (NUM_COLUMNS > MAX_REPORT) ? MAX_REPORT : NUM_COLUMNS;
    localparam int K_W = (REP > 1) ? $clog2(REP) : 1;
    localparam logic [ROW_W-1:0] ROW_MASK =
        (NUM_ROWS >= ROW_W) ? {ROW_W{1'b1}} : ROW_W'((1 << NUM_ROWS) - 1);
    localparam logic [COL_W:0] COL_LIMIT = (NUM_COLUMNS > MAX_REPORT) ?
        (COL_W+1)'(MAX_REPORT) : (COL_W+1)'(NUM_COLUMNS);
    localparam logic [K_W-1:0] K_LAST = K_W'(REP - 1);

    logic [ROW_W-1:0]   r_prev [REP];
    logic [ROW_W-1:0]   r_deb  [REP];
    logic               r_change_seen;
    logic [TIME_W-1:0]  r_last_us;
    logic [TIME_W-1:0]  r_now;
    logic               r_changed;
    logic               r_latch;
    logic [QUIET_W-1:0] r_quiet;
    logic [K_W-1:0]     r_k;

    logic               r_out_valid;
    logic [COL_W-1:0]   r_out_column;
    logic [ROW_W-1:0]   r_out_keys;
    logic               r_out_latched;
    logic               r_out_changed;
    logic               r_out_last;

    logic [ROW_W-1:0]   w_bits;
    logic               w_in_range;
    logic [K_W-1:0]     w_col_idx;
    logic               w_diff;
    logic [TIME_W-1:0]  w_elapsed;
    logic               w_latch;

    assign w_bits     = i_in.row_bits & ROW_MASK;
    assign w_in_range = {1'b0, i_in.column} < COL_LIMIT;
    assign w_col_idx  = i_in.column[K_W-1:0];
    assign w_diff     = w_in_range && (r_prev[w_col_idx] != w_bits);

    // A change this scan blocks the latch and resets the timer to now.
    assign w_elapsed = r_now - r_last_us;
    assign w_latch   = !r_changed && (w_elapsed > TIME_W'(r_quiet));

    assign o_sts.in_valid = i_in.valid;
    assign o_sts.eos      = i_in.end_of_scan;
    assign o_sts.out_free = !r_out_valid || o_out.ready;
    assign o_sts.last_col = (r_k == K_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REP; i++) begin
                r_prev[i] <= '0;
                r_deb[i]  <= '0;
            end
            r_change_seen <= 1'b0;
            r_last_us     <= '0;
            r_changed     <= 1'b0;
            r_latch       <= 1'b0;
            r_quiet       <= QUIET_RESET;
            r_k           <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_quiet <= i_cfg_wdata;
            end

            if (i_cmd.accept) begin
                if (w_in_range) begin
                    r_prev[w_col_idx] <= w_bits;
                end
                if (i_in.end_of_scan) begin
                    r_now     <= i_in.now_us;
                    r_changed <= r_change_seen || w_diff;
                end
                if (w_diff) begin
                    r_change_seen <= 1'b1;
                end
            end

            if (i_cmd.eval) begin
                r_change_seen <= 1'b0;
                r_latch       <= w_latch;
                r_k           <= '0;
                if (r_changed || w_latch) begin
                    r_last_us <= r_now;
                end
                if (w_latch) begin
                    for (int i = 0; i < REP; i++) begin
                        r_deb[i] <= r_prev[i];
                    end
                end
            end

            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
                if (r_k != K_LAST) begin
                    r_k <= r_k + 1'b1;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_column  <= COL_W'(r_k);
            r_out_keys    <= r_deb[r_k];
            r_out_latched <= r_latch;
            r_out_changed <= r_changed;
            r_out_last    <= (r_k == K_LAST);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_column   = r_out_column;
    assign o_out.keys_down    = r_out_keys;
    assign o_out.latched      = r_out_latched;
    assign o_out.scan_changed = r_out_changed;
    assign o_out.last_of_run  = r_out_last;
    assign o_quiet            = r_quiet;

endmodule

FILE: rtl/core/key_matrix_scan_debouncer.sv
// Key matrix scan debouncer: a column sample that does not end a scan is accepted while idle.
// An end-of-scan sample is accepted, then the EVAL state makes the quiet-timer decision;
// the EMIT state then loads the column results into the output register, one column per cycle
// while the sink is ready (up to MAX_REPORT = 16 results; the column counter walks them).
// No new sample is taken until the last result is loaded. Synchronous active-low reset clears
// both key stores, the timer and change flag, and sets quiet_time_us to 4000.
module key_matrix_scan_debouncer #(
    parameter int NUM_COLUMNS = kmsd_pkg::NUM_COLUMNS_DEF,
    parameter int NUM_ROWS    = kmsd_pkg::NUM_ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    kmsd_in_if.sink                           i_in_ch,
    kmsd_out_if.source                        o_out_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kmsd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [kmsd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [kmsd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import kmsd_pkg::*;

    t_ctl_cmd           w_cmd;
    t_ctl_sts           w_sts;
    logic               w_in_ready;
    logic               w_cfg_we;
    logic               w_reg_sel;
    logic [QUIET_W-1:0] w_quiet;

    // Word address bit picks the register; byte offset bits are ignored
    assign w_reg_sel = paddr[APB_ADDR_W-1];
    assign w_cfg_we  = psel && penable && pwrite && (w_reg_sel == REG_QUIET_TIME);
    assign pready    = 1'b1;
    assign prdata    = (w_reg_sel == REG_QUIET_TIME) ? APB_DATA_W'(w_quiet) : '0;

    assign i_in_ch.ready = w_in_ready;

    kmsd_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    kmsd_dp #(
        .NUM_COLUMNS (NUM_COLUMNS),
        .NUM_ROWS    (NUM_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in_ch),
        .o_out       (o_out_ch),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_wdata (pwdata[QUIET_W-1:0]),
        .o_quiet     (w_quiet)
    );

endmodule

FILE: bench/key_matrix_scan_debouncer_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for key_matrix_scan_debouncer: column samples in, debounced column reports out.
// Depends on kmsd_pkg, kmsd_in_if, kmsd_out_if and the RTL top; quiet time is set over the APB port.
module key_matrix_scan_debouncer_tb;
    import kmsd_pkg::*;

    localparam int NCOL          = NUM_COLUMNS_DEF;
    localparam int REPORTED      = (NCOL > MAX_REPORT) ? MAX_REPORT : NCOL;
    localparam int RANDOM_ITEMS  = 320;
    localparam int PHASES        = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;     // settle margin after the scoreboard has drained
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_PRINTS    = 30;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] keys_down;
        logic             latched;
        logic             scan_changed;
        logic             last_of_run;
    } t_column_report;

    // Predicts the column reports of each scan and checks them in order.
    class t_debounce_scoreboard;
        logic [QUIET_W-1:0] quiet_us;
        logic [ROW_W-1:0]   sampled [NCOL];
        logic [ROW_W-1:0]   stable [NCOL];
        logic               change_pending;
        logic [TIME_W-1:0]  last_change_us;
        t_column_report     reports_due [$];
        int                 errors;
        int                 checked;
        int                 latch_reports;

        function new();
            quiet_us = QUIET_RESET;
            foreach (sampled[c]) begin
                sampled[c] = '0;
                stable[c]  = '0;
            end
            change_pending = 1'b0;
            last_change_us = '0;
            errors = 0;
            checked = 0;
            latch_reports = 0;
        endfunction

        function void note_sample(logic [COL_W-1:0] col, logic [ROW_W-1:0] bits,
                                  logic [TIME_W-1:0] now_us, logic eos);
            logic           changed;
            logic           take;
            t_column_report rep;
            if (int'(col) < NCOL) begin
                if (sampled[col] != bits)
                    change_pending = 1'b1;
                sampled[col] = bits;
            end
            if (!eos)
                return;
            changed = change_pending;
            if (changed)
                last_change_us = now_us;
            // wrap-safe elapsed time; a backward step reads as a long quiet stretch
            take = (now_us - last_change_us) > TIME_W'(quiet_us);
            if (take) begin
                last_change_us = now_us;
                stable = sampled;
            end
            change_pending = 1'b0;
            for (int c = 0; c < REPORTED; c++) begin
                rep.column       = COL_W'(c);
                rep.keys_down    = stable[c];
                rep.latched      = take;
                rep.scan_changed = changed;
                rep.last_of_run  = (c == REPORTED - 1);
                reports_due.push_back(rep);
            end
        endfunction

        task report_mismatch(string what);
            if (errors < MAX_PRINTS)
                $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_column(t_column_report got);
            t_column_report want;
            if (reports_due.size() == 0) begin
                report_mismatch($sformatf("column %0d reported with nothing pending",
                                          got.column));
                return;
            end
            want = reports_due.pop_front();
            checked++;
            if (got !== want)
                report_mismatch($sformatf(
                    "col %0d/%0d keys %b/%b latched %b/%b changed %b/%b last %b/%b (got/exp)",
                    got.column, want.column, got.keys_down, want.keys_down,
                    got.latched, want.latched, got.scan_changed, want.scan_changed,
                    got.last_of_run, want.last_of_run));
            else if (got.latched && got.last_of_run)
                latch_reports++;
        endtask

        function int outstanding();
            return reports_due.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    kmsd_in_if  in_ch ();
    kmsd_out_if out_ch ();

    key_matrix_scan_debouncer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    t_debounce_scoreboard sb = new();
    int                 cycle_count = 0;
    int                 samples_sent = 0;
    bit                 calm = 1'b0;
    bit                 hold_req = 1'b0;
    logic [ROW_W-1:0]   key_image [NCOL];
    logic [TIME_W-1:0]  clock_us;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[key_matrix_scan_debouncer] ERROR");
            $finish;
        end
    end

    // result monitor: values read here are the ones from before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_column({out_ch.out_column, out_ch.keys_down, out_ch.latched,
                             out_ch.scan_changed, out_ch.last_of_run});
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] bits,
                             input logic [TIME_W-1:0] now_us, input logic eos);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.column      <= col;
        in_ch.row_bits    <= bits;
        in_ch.now_us      <= now_us;
        in_ch.end_of_scan <= eos;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_sample(col, bits, now_us, eos);
        samples_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one APB transfer to the quiet time register, followed by an idle bus
    task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_QUIET_TIME, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int                  goal;
        int                  first;
        int                  count;
        logic [QUIET_W-1:0]  quiet;
        logic [APB_DATA_W-1:0] readback;
        logic [TIME_W-1:0]   step_us;

        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.column      <= '0;
        in_ch.row_bits    <= '0;
        in_ch.now_us      <= '0;
        in_ch.end_of_scan <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        clock_us = $urandom;
        foreach (key_image[c])
            key_image[c] = '0;
        quiet = QUIET_RESET;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: boundary of the quiet time, sticky change flag, backward and wrapping time
        send_item(4'd0,  5'h1F, 32'd0, 1'b0);
        send_item(4'd15, 5'h1F, 32'd1, 1'b1);
        send_item(4'd15, 5'h1F, 32'd4001, 1'b1);    // exactly the quiet time: no latch
        send_item(4'd15, 5'h1F, 32'd4002, 1'b1);    // one past: latch
        send_item(4'd0,  5'h00, 32'd5000, 1'b0);
        send_item(4'd3,  5'h0A, 32'd5001, 1'b0);
        send_item(4'd12, 5'h15, 32'd5002, 1'b1);
        send_item(4'd12, 5'h15, 32'd100, 1'b1);     // time stepped back
        send_item(4'd7,  5'h10, 32'hFFFF_FFFF, 1'b1);
        send_item(4'd7,  5'h10, 32'h0000_0FA0, 1'b1); // elapsed across the wrap
        send_item(4'd9,  5'h01, 32'h8000_0000, 1'b0);
        send_item(4'd9,  5'h02, 32'h8000_0001, 1'b0);
        send_item(4'd9,  5'h00, 32'h8000_0002, 1'b0); // back to stored value, flag stays set
        send_item(4'd15, 5'h1F, 32'hFFFF_0000, 1'b1);
        send_item(4'd15, 5'h1F, 32'h0000_0000, 1'b1);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       quiet = '0;
                1:       quiet = QUIET_W'(1000000);
                2:       quiet = QUIET_RESET;
                default: quiet = QUIET_W'($urandom_range(1, 999999));
            endcase
            apb_access(1'b1, APB_DATA_W'(quiet), readback);
            sb.quiet_us = quiet;
            apb_access(1'b0, '0, readback);
            if (readback !== APB_DATA_W'(quiet))
                sb.report_mismatch($sformatf("quiet time read back %0d, wrote %0d",
                                             readback, quiet));
            calm = (p == PHASES - 1);
            if (p == 1)
                hold_req = 1'b1;

            goal = samples_sent + RANDOM_ITEMS / PHASES;
            while (samples_sent < goal) begin
                if ($urandom_range(0, 9) < 8) begin
                    // well-formed scan: ascending columns, one timestamp, end mark on the last
                    if ($urandom_range(0, 2) == 0)
                        key_image[$urandom_range(0, NCOL - 1)] = ROW_W'($urandom);
                    if ($urandom_range(0, 3) == 0) begin
                        first = 0;
                        count = NCOL;
                    end else begin
                        first = $urandom_range(0, NCOL - 1);
                        count = $urandom_range(1, (NCOL - first < 6) ? NCOL - first : 6);
                    end
                    case ($urandom_range(0, 5))
                        0, 1:    step_us = $urandom_range(0, quiet);
                        2:       step_us = TIME_W'(quiet);
                        3:       step_us = TIME_W'(quiet) + 1;
                        4:       step_us = TIME_W'(quiet) + $urandom_range(2, 3000);
                        default: step_us = $urandom;    // long jump, may land backwards
                    endcase
                    clock_us = clock_us + step_us;
                    for (int c = first; c < first + count; c++)
                        send_item(COL_W'(c), key_image[c], clock_us, c == first + count - 1);
                end else begin
                    send_item(COL_W'($urandom), ROW_W'($urandom), $urandom,
                              1'($urandom_range(0, 1)));
                end
            end
            wait_drained();
        end

        $display("covered %0d column samples and %0d column reports, %0d scans latched",
                 samples_sent, sb.checked, sb.latch_reports);
        $display("quiet times: reset value, 0, 1000000 and %0d us, time wrapping and going back",
                 quiet);
        if (sb.errors == 0)
            $display("[key_matrix_scan_debouncer] OK");
        else
            $display("[key_matrix_scan_debouncer] ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/kmsd_pkg.sv
rtl/core/kmsd_in_if.sv
rtl/core/kmsd_out_if.sv
rtl/core/kmsd_ctl.sv
rtl/core/kmsd_dp.sv
rtl/core/key_matrix_scan_debouncer.sv
bench/key_matrix_scan_debouncer_tb.sv
